// ===== design/image_flip_mirror_unit_defines.svh =====
// Assertion macros shared by the checker of the image flip and mirror unit.
`ifndef IMAGE_FLIP_MIRROR_UNIT_DEFINES_SVH
`define IMAGE_FLIP_MIRROR_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define IFMU_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define IFMU_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/ifmu_pkg.sv =====
// Package with the types, constants and helpers of the image flip and mirror unit.
`default_nettype none

package ifmu_pkg;

  localparam int MAX_WIDTH  = 256;
  localparam int MAX_HEIGHT = 256;
  localparam int PIXEL_BITS = 8;

  localparam int SIZE_BITS   = 9;
  localparam int MODE_BITS   = 2;
  localparam int COL_BITS    = $clog2(MAX_WIDTH);
  localparam int ROW_BITS    = $clog2(MAX_HEIGHT);
  localparam int STORE_DEPTH = 2 * MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_BITS   = $clog2(STORE_DEPTH);

  localparam int FIFO_DEPTH     = 4;
  localparam int FIFO_PTR_BITS  = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_BITS  = $clog2(FIFO_DEPTH + 1);

  localparam int CFG_DATA_BITS = 32;
  localparam int CFG_ADDR_BITS = 4;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_DRAIN = 1'b1;

  typedef enum logic [MODE_BITS-1:0] {
    FLIP_VERT  = 2'd0,
    FLIP_HORIZ = 2'd1,
    FLIP_BOTH  = 2'd2
  } orient_e;

  typedef enum logic [1:0] {
    REG_FRAME_WIDTH  = 2'd0,
    REG_FRAME_HEIGHT = 2'd1,
    REG_ORIENT       = 2'd2
  } reg_idx_e;

  typedef struct packed {
    logic [SIZE_BITS-1:0] frame_width;
    logic [SIZE_BITS-1:0] frame_height;
    logic [MODE_BITS-1:0] orient;
  } cfg_t;

  typedef struct packed {
    logic                  we;
    logic [ADDR_BITS-1:0]  waddr;
    logic [PIXEL_BITS-1:0] wdata;
    logic                  re;
    logic [ADDR_BITS-1:0]  raddr;
    logic                  eol;
    logic                  eof;
  } op_t;

  // Sizes of zero act as one and sizes above the maximum act as the maximum.
  function automatic logic [SIZE_BITS-1:0] clamp_size(input logic [SIZE_BITS-1:0] v,
                                                     input logic [SIZE_BITS-1:0] maxv);
    logic [SIZE_BITS-1:0] res;
    if (v == '0) begin
      res = SIZE_BITS'(1);
    end else if (v > maxv) begin
      res = maxv;
    end else begin
      res = v;
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// ===== design/image_flip_mirror_unit.sv =====
// Top level of the image flip and mirror unit with its configuration registers.
// Pixels enter in raster order on the input channel (in_valid_i, in_stall_o, cmd_i,
// pixel_in_i) and are written into one bank of a double-buffered frame store.
// When the last pixel of a frame is written, the banks swap and the finished frame
// is held; from the next request on, every request, write or drain, yields one
// pixel of the held frame in flipped order on the output channel (out_valid_o,
// out_stall_i, pixel_out_o, end_of_line_o, end_of_frame_o). A request with no
// frame held yields nothing. Frame width, frame height and flip mode are set over
// the APB port; the user must set them only while the block is idle, which the
// block itself does not enforce. One request is taken per cycle while in_stall_o
// is low; a result passes through the operation queue, the registered read of the
// frame store and the output register, in that order.
// When the receiver stalls, the output register holds, the back end stops and the
// four-entry operation queue fills; in_stall_o rises once it is full.
// Reset clears the position counters and the held-frame flag and loads the size
// registers with the maximum frame size; the frame store itself is not cleared.
`default_nettype none

module image_flip_mirror_unit import ifmu_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic                     cmd_i,
  input  logic [PIXEL_BITS-1:0]    pixel_in_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic [PIXEL_BITS-1:0]    pixel_out_o,
  output logic                     end_of_line_o,
  output logic                     end_of_frame_o,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [CFG_ADDR_BITS-1:0] paddr,
  input  logic [CFG_DATA_BITS-1:0] pwdata,
  output logic [CFG_DATA_BITS-1:0] prdata,
  output logic                     pready
);

  cfg_t cfg_q, cfg_d;
  logic cfg_write;
  logic fifo_full, push, pop, op_valid;
  op_t  front_op, back_op;

  always_comb begin
    pready    = 1'b1;
    cfg_write = psel && penable && pwrite && pready;
    cfg_d     = cfg_q;
    if (cfg_write) begin
      case (paddr[3:2])
        REG_FRAME_WIDTH:  cfg_d.frame_width  = pwdata[SIZE_BITS-1:0];
        REG_FRAME_HEIGHT: cfg_d.frame_height = pwdata[SIZE_BITS-1:0];
        REG_ORIENT:       cfg_d.orient       = pwdata[MODE_BITS-1:0];
        default:          cfg_d              = cfg_q;
      endcase
    end
    case (paddr[3:2])
      REG_FRAME_WIDTH:  prdata = CFG_DATA_BITS'(cfg_q.frame_width);
      REG_FRAME_HEIGHT: prdata = CFG_DATA_BITS'(cfg_q.frame_height);
      REG_ORIENT:       prdata = CFG_DATA_BITS'(cfg_q.orient);
      default:          prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.frame_width  <= SIZE_BITS'(MAX_WIDTH);
      cfg_q.frame_height <= SIZE_BITS'(MAX_HEIGHT);
      cfg_q.orient       <= FLIP_VERT;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  ifmu_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .cmd_i       (cmd_i),
    .pixel_in_i  (pixel_in_i),
    .cfg_i       (cfg_q),
    .fifo_full_i (fifo_full),
    .push_o      (push),
    .op_o        (front_op)
  );

  ifmu_op_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .op_i    (front_op),
    .full_o  (fifo_full),
    .pop_i   (pop),
    .valid_o (op_valid),
    .op_o    (back_op)
  );

  ifmu_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .op_valid_i     (op_valid),
    .op_i           (back_op),
    .pop_o          (pop),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .pixel_out_o    (pixel_out_o),
    .end_of_line_o  (end_of_line_o),
    .end_of_frame_o (end_of_frame_o)
  );

endmodule

`default_nettype wire

// ===== design/ifmu_ram.sv =====
// Generic single write port, single read port RAM with a registered read.
`default_nettype none

module ifmu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== design/ifmu_front.sv =====
// Front end: accepts requests, tracks write and read positions and builds store operations.
`default_nettype none

module ifmu_front import ifmu_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic                  cmd_i,
  input  logic [PIXEL_BITS-1:0] pixel_in_i,
  input  cfg_t                  cfg_i,
  input  logic                  fifo_full_i,
  output logic                  push_o,
  output op_t                   op_o
);

  logic                 accept;
  logic [SIZE_BITS-1:0] w_eff, h_eff, w_eff_m1, h_eff_m1;
  logic [COL_BITS-1:0]  w_m1, sc, wc;
  logic [ROW_BITS-1:0]  h_m1, sr, wr;
  logic                 vert, horiz, rd_eol, rd_eof, col_over;

  logic [COL_BITS-1:0] write_col_q, write_col_d, read_col_q, read_col_d;
  logic [ROW_BITS-1:0] write_row_q, write_row_d, read_row_q, read_row_d;
  logic [COL_BITS-1:0] held_w_m1_q, held_w_m1_d;
  logic [ROW_BITS-1:0] held_h_m1_q, held_h_m1_d;
  logic                write_bank_q, write_bank_d, frame_ready_q, frame_ready_d;

  always_comb begin
    accept   = in_valid_i && !fifo_full_i;
    w_eff    = clamp_size(cfg_i.frame_width, SIZE_BITS'(MAX_WIDTH));
    h_eff    = clamp_size(cfg_i.frame_height, SIZE_BITS'(MAX_HEIGHT));
    w_eff_m1 = w_eff - SIZE_BITS'(1);
    h_eff_m1 = h_eff - SIZE_BITS'(1);
    w_m1     = w_eff_m1[COL_BITS-1:0];
    h_m1     = h_eff_m1[ROW_BITS-1:0];
    vert     = cfg_i.orient != FLIP_HORIZ;
    horiz    = cfg_i.orient != FLIP_VERT;

    sc     = horiz ? (held_w_m1_q - read_col_q) : read_col_q;
    sr     = vert ? (held_h_m1_q - read_row_q) : read_row_q;
    rd_eol = read_col_q == held_w_m1_q;
    rd_eof = rd_eol && (read_row_q == held_h_m1_q);

    col_over = write_col_q > w_m1;
    if (col_over) begin
      wc = '0;
      wr = (write_row_q < h_m1) ? (write_row_q + ROW_BITS'(1)) : '0;
    end else begin
      wc = write_col_q;
      wr = (write_row_q > h_m1) ? h_m1 : write_row_q;
    end

    write_col_d   = write_col_q;
    write_row_d   = write_row_q;
    write_bank_d  = write_bank_q;
    read_col_d    = read_col_q;
    read_row_d    = read_row_q;
    frame_ready_d = frame_ready_q;
    held_w_m1_d   = held_w_m1_q;
    held_h_m1_d   = held_h_m1_q;

    op_o.we    = 1'b0;
    op_o.waddr = {write_bank_q, wr, wc};
    op_o.wdata = pixel_in_i;
    op_o.re    = 1'b0;
    op_o.raddr = {~write_bank_q, sr, sc};
    op_o.eol   = rd_eol;
    op_o.eof   = rd_eof;

    if (accept && frame_ready_q) begin
      op_o.re = 1'b1;
      if (rd_eof) begin
        frame_ready_d = 1'b0;
        read_col_d    = '0;
        read_row_d    = '0;
      end else if (rd_eol) begin
        read_col_d = '0;
        read_row_d = read_row_q + ROW_BITS'(1);
      end else begin
        read_col_d = read_col_q + COL_BITS'(1);
      end
    end

    if (accept && (cmd_i == CMD_WRITE)) begin
      op_o.we = 1'b1;
      if (wc == w_m1) begin
        write_col_d = '0;
        if (wr == h_m1) begin
          write_row_d   = '0;
          write_bank_d  = ~write_bank_q;
          frame_ready_d = 1'b1;
          held_w_m1_d   = w_m1;
          held_h_m1_d   = h_m1;
          read_col_d    = '0;
          read_row_d    = '0;
        end else begin
          write_row_d = wr + ROW_BITS'(1);
        end
      end else begin
        write_col_d = wc + COL_BITS'(1);
        write_row_d = wr;
      end
    end

    push_o     = accept && (op_o.we || op_o.re);
    in_stall_o = fifo_full_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      write_col_q   <= '0;
      write_row_q   <= '0;
      write_bank_q  <= 1'b0;
      read_col_q    <= '0;
      read_row_q    <= '0;
      frame_ready_q <= 1'b0;
      held_w_m1_q   <= '0;
      held_h_m1_q   <= '0;
    end else begin
      write_col_q   <= write_col_d;
      write_row_q   <= write_row_d;
      write_bank_q  <= write_bank_d;
      read_col_q    <= read_col_d;
      read_row_q    <= read_row_d;
      frame_ready_q <= frame_ready_d;
      held_w_m1_q   <= held_w_m1_d;
      held_h_m1_q   <= held_h_m1_d;
    end
  end

endmodule

`default_nettype wire

// ===== design/ifmu_op_fifo.sv =====
// Short queue of store operations between the front end and the back end.
`default_nettype none

module ifmu_op_fifo import ifmu_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  op_t  op_i,
  output logic full_o,
  input  logic pop_i,
  output logic valid_o,
  output op_t  op_o
);

  op_t                     mem_q [FIFO_DEPTH];
  logic [FIFO_PTR_BITS-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [FIFO_CNT_BITS-1:0] count_q, count_d;
  logic                     do_push, do_pop;

  always_comb begin
    valid_o = count_q != '0;
    full_o  = count_q == FIFO_CNT_BITS'(FIFO_DEPTH);
    op_o    = mem_q[rd_ptr_q];
    do_push = push_i && !full_o;
    do_pop  = pop_i && valid_o;

    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == FIFO_PTR_BITS'(FIFO_DEPTH - 1)) ? '0
                                                               : wr_ptr_q + FIFO_PTR_BITS'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == FIFO_PTR_BITS'(FIFO_DEPTH - 1)) ? '0
                                                               : rd_ptr_q + FIFO_PTR_BITS'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + FIFO_CNT_BITS'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - FIFO_CNT_BITS'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= op_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

`default_nettype wire

// ===== design/ifmu_back.sv =====
// Back end: runs store operations on the frame store and delivers the read pixels.
`default_nettype none

module ifmu_back import ifmu_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  op_valid_i,
  input  op_t                   op_i,
  output logic                  pop_o,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [PIXEL_BITS-1:0] pixel_out_o,
  output logic                  end_of_line_o,
  output logic                  end_of_frame_o
);

  logic                  move_rd, issue_ok, ram_we, ram_re;
  logic [PIXEL_BITS-1:0] ram_rdata;
  logic                  rd_valid_q, rd_valid_d, out_valid_q, out_valid_d;
  logic                  rd_eol_q, rd_eof_q;
  logic [PIXEL_BITS-1:0] pixel_q;
  logic                  eol_q, eof_q;

  always_comb begin
    move_rd  = rd_valid_q && (!out_valid_q || !out_stall_i);
    issue_ok = !rd_valid_q || move_rd;
    pop_o    = op_valid_i && issue_ok;
    ram_we   = pop_o && op_i.we;
    ram_re   = pop_o && op_i.re;

    rd_valid_d = rd_valid_q;
    if (ram_re) begin
      rd_valid_d = 1'b1;
    end else if (move_rd) begin
      rd_valid_d = 1'b0;
    end

    out_valid_d = out_valid_q;
    if (move_rd) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  ifmu_ram #(
    .WIDTH (PIXEL_BITS),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (op_i.waddr),
    .wdata_i (op_i.wdata),
    .re_i    (ram_re),
    .raddr_i (op_i.raddr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i) begin
    if (ram_re) begin
      rd_eol_q <= op_i.eol;
      rd_eof_q <= op_i.eof;
    end
    if (move_rd) begin
      pixel_q <= ram_rdata;
      eol_q   <= rd_eol_q;
      eof_q   <= rd_eof_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      rd_valid_q  <= rd_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign pixel_out_o    = pixel_q;
  assign end_of_line_o  = eol_q;
  assign end_of_frame_o = eof_q;

endmodule

`default_nettype wire

// ===== design/ifmu_checker.sv =====
// Port-level checker of the image flip and mirror unit and its bind to the top level.
`default_nettype none
`include "image_flip_mirror_unit_defines.svh"

module ifmu_checker import ifmu_pkg::*; (
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     out_valid_o,
  input logic                     out_stall_i,
  input logic [PIXEL_BITS-1:0]    pixel_out_o,
  input logic                     end_of_line_o,
  input logic                     end_of_frame_o,
  input logic                     psel,
  input logic                     penable,
  input logic                     pwrite,
  input logic [CFG_ADDR_BITS-1:0] paddr,
  input logic [CFG_DATA_BITS-1:0] pwdata,
  input logic [CFG_DATA_BITS-1:0] prdata
);

  `IFMU_ASSERT_NEXT(a_out_valid_held, out_valid_o && out_stall_i, out_valid_o, "result withdrawn while stalled")

  `IFMU_ASSERT_NEXT(a_out_payload_held, out_valid_o && out_stall_i, $stable(pixel_out_o) && $stable(end_of_line_o) && $stable(end_of_frame_o), "stalled result changed")

  `IFMU_ASSERT_NOW(a_eof_is_eol, out_valid_o && end_of_frame_o, end_of_line_o, "end of frame without end of line")

  `IFMU_ASSERT_NOW(a_width_readback, (psel && penable && pwrite && (paddr[3:2] == REG_FRAME_WIDTH)) ##1 (psel && !pwrite && (paddr[3:2] == REG_FRAME_WIDTH)), prdata[SIZE_BITS-1:0] == $past(pwdata[SIZE_BITS-1:0]), "frame width reads back wrong")

endmodule

bind image_flip_mirror_unit ifmu_checker u_checker (.*);

`default_nettype wire
